[design/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Default number of entries
    localparam int CAPACITY_DEF = 128;

    // Field widths
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 8;
    localparam int OUT_TDATA_W  = 48;

    // Operation codes carried on the input tuser
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Command broadcast to every cell
    typedef struct packed {
        logic ins;      // insert the broadcast value
        logic del;      // remove the head entry
    } spq_ctrl_t;

    // What one cell shows its neighbours
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      valid;
        logic                      take;   // cell is at or behind the insert point
    } spq_link_t;

    localparam spq_link_t LINK_NONE = '{value: '0, valid: 1'b0, take: 1'b0};

endpackage

[design/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One place of the sorted store: holds a value and its valid bit, shifts
// towards the tail on an insert ahead of it and towards the head on a removal.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  spq_pkg::spq_ctrl_t                ctrl,
    input  logic signed [spq_pkg::VALUE_W-1:0] ins_value,
    input  spq_pkg::spq_link_t                prev_link,   // cell nearer the head
    input  spq_pkg::spq_link_t                next_link,   // cell nearer the tail
    output spq_pkg::spq_link_t                own_link
);

    logic signed [spq_pkg::VALUE_W-1:0] value_reg;
    logic signed [spq_pkg::VALUE_W-1:0] value_next;
    logic                               valid_reg;
    logic                               valid_next;
    logic                               take;

    // An empty place or a value not below the new one yields to the insert
    assign take = !valid_reg || (value_reg >= ins_value);

    // Choose the next content of this place
    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.del) begin
            value_next = next_link.value;
            valid_next = next_link.valid;
        end else if (ctrl.ins && take) begin
            if (prev_link.take) begin
                value_next = prev_link.value;
                valid_next = prev_link.valid;
            end else begin
                value_next = ins_value;
                valid_next = 1'b1;
            end
        end
    end

    // Hold the value; no reset on payload
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    // Hold the valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign own_link = '{value: value_reg, valid: valid_reg, take: take};

endmodule

[design/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded min-priority queue of signed 32-bit values, kept in ascending order
// in a row of cells; each item either inserts a value or removes the smallest.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                     | tuser
//  s_      | in  | in_value[31:0]            | opcode (0 enqueue, 1 dequeue)
//  m_      | out | out_value, accepted,      | -
//          |     | is_empty, is_full, count  |
//
//  One item per cycle while s_tready is high: every cell compares the broadcast
//  value with its own in the same cycle and shifts one place.
//  The result appears on m_ in the cycle after the item is taken.
//  s_tready is high while the output register is empty or being emptied.
//  Reset clears the valid bits, the count and the output valid bit; no pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [spq_pkg::VALUE_W-1:0]     s_tdata,   // [31:0] in_value
    input  logic                            s_tuser,   // [0] opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [spq_pkg::OUT_TDATA_W-1:0] m_tdata    // [31:0] out_value, [32] accepted,
                                                       // [33] is_empty, [34] is_full,
                                                       // [42:35] count, [47:43] zero
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic                               m_tvalid_reg;
    logic                               m_tvalid_next;
    logic [spq_pkg::OUT_TDATA_W-1:0]    m_tdata_reg;
    logic [spq_pkg::OUT_TDATA_W-1:0]    m_tdata_next;
    logic                               take_item;
    logic                               full;
    logic                               empty;
    spq_pkg::spq_ctrl_t                 ctrl;
    logic signed [spq_pkg::VALUE_W-1:0] ins_value;
    spq_pkg::spq_link_t                 links [CAPACITY];
    logic [CW+spq_pkg::COUNT_W-1:0]     count_ext;
    logic [spq_pkg::VALUE_W-1:0]        out_value;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign take_item = s_tvalid && s_tready;
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign ins_value = s_tdata;

    // Decode the operation; drop inserts when full, removals when empty
    assign ctrl.ins = take_item && (s_tuser == spq_pkg::OP_ENQUEUE) && !full;
    assign ctrl.del = take_item && (s_tuser == spq_pkg::OP_DEQUEUE) && !empty;

    // Row of cells, head at index 0
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        spq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .ins_value (ins_value),
            .prev_link ((i == 0) ? spq_pkg::LINK_NONE : links[(i == 0) ? 0 : i-1]),
            .next_link ((i == CAPACITY-1) ? spq_pkg::LINK_NONE
                                          : links[(i == CAPACITY-1) ? i : i+1]),
            .own_link  (links[i])
        );
    end

    // Advance the entry count
    always_comb begin
        count_next = count_reg;
        if (ctrl.ins) begin
            count_next = count_reg + CW'(1);
        end else if (ctrl.del) begin
            count_next = count_reg - CW'(1);
        end
    end

    // Build the result item
    assign count_ext = {{spq_pkg::COUNT_W{1'b0}}, count_next};
    assign out_value = ctrl.del ? links[0].value : '0;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (take_item) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'b0,
                             count_ext[spq_pkg::COUNT_W-1:0],
                             (count_next == CW'(CAPACITY)),
                             (count_next == '0),
                             (ctrl.ins || ctrl.del),
                             out_value};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[design/spq_checker.sv]
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [spq_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // A refused operation returns zero
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[32] |-> (m_tdata[31:0] == 32'd0))
        else $error("refused operation returned a value");

    // Empty and full never together
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[33] && m_tdata[34]))
        else $error("queue reported empty and full");

    // Empty means a zero count
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33] |-> (m_tdata[42:35] == 8'd0))
        else $error("empty queue with non-zero count");

    // An accepted item always yields a result next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item gave no result");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
